/* src/keyed_byte_scrambler_macros.svh */
// Assertion macros shared by the keyed byte scrambler RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef KEYED_BYTE_SCRAMBLER_MACROS_SVH
`define KEYED_BYTE_SCRAMBLER_MACROS_SVH

// Implication checked from the same cycle.
`define KBS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define KBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/kbs_pkg.sv */
// Shared types and constants for the keyed byte scrambler.
// No dependencies; used by every module of the block.
`default_nettype none

package kbs_pkg;

    // Number of key byte slots.
    localparam int KEY_DEPTH = 8;
    localparam int KEY_IDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES  = 2'd3;

    // Mode codes.
    localparam logic MODE_DECODE = 1'b0;
    localparam logic MODE_ENCODE = 1'b1;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic        mode;
        logic [31:0] period;
        logic [3:0]  key_length;
        logic [63:0] key_bytes;
    } cfg_t;

endpackage

`default_nettype wire

/* src/kbs_cfg_regs.sv */
// Configuration register file of the keyed byte scrambler.
// Depends on kbs_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module kbs_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write_en,
    input  wire logic [kbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kbs_pkg::CFG_DATA_W-1:0] cfg_data,
    output kbs_pkg::cfg_t                       cfg
);

    kbs_pkg::cfg_t cfg_reg;

    // Registers are written by index; reset restores the documented defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= kbs_pkg::MODE_DECODE;
            cfg_reg.period     <= 32'd1;
            cfg_reg.key_length <= 4'd1;
            cfg_reg.key_bytes  <= 64'd0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                kbs_pkg::REG_MODE:       cfg_reg.mode       <= cfg_data[0];
                kbs_pkg::REG_PERIOD:     cfg_reg.period     <= cfg_data[31:0];
                kbs_pkg::REG_KEY_LENGTH: cfg_reg.key_length <= cfg_data[3:0];
                kbs_pkg::REG_KEY_BYTES:  cfg_reg.key_bytes  <= cfg_data;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* src/kbs_key_gen.sv */
// Key stream generator: position, period phase and key index counters and
// the per-byte offset they produce. Depends on kbs_pkg and the macro header.
`default_nettype none
`include "keyed_byte_scrambler_macros.svh"

module kbs_key_gen (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire kbs_pkg::cfg_t cfg,
    input  wire logic          start_of_file,
    input  wire logic          advance,
    output logic [7:0]         delta
);

    localparam int IW = kbs_pkg::KEY_IDX_W;

    logic [7:0]    position_low_reg, position_low_next;
    logic [31:0]   period_phase_reg, period_phase_next;
    logic [IW-1:0] key_index_reg, key_index_next;

    logic [7:0]    pos_cur;
    logic [31:0]   phase_cur;
    logic [IW-1:0] kidx_cur;
    logic [IW-1:0] last_index;
    logic [32:0]   phase_inc;
    logic [7:0]    key_byte;
    logic [7:0]    mixed;

    // A start of file request begins from a cleared position, phase and key index.
    assign pos_cur   = start_of_file ? 8'd0 : position_low_reg;
    assign phase_cur = start_of_file ? 32'd0 : period_phase_reg;
    assign kidx_cur  = start_of_file ? '0 : key_index_reg;

    // Last key slot in use; a zero length acts as one, a long one saturates.
    always_comb
    begin
        priority if (cfg.key_length == 4'd0)
            last_index = '0;
        else if (32'(cfg.key_length) >= kbs_pkg::KEY_DEPTH)
            last_index = IW'(kbs_pkg::KEY_DEPTH - 1);
        else
            last_index = IW'(cfg.key_length - 4'd1);
    end

    // The key index steps before use and wraps after the last slot.
    assign key_index_next = (kidx_cur >= last_index) ? '0 : IW'(kidx_cur + 1'b1);
    assign key_byte       = cfg.key_bytes[8 * key_index_next +: 8];

    // Offset: position XOR key byte, plus the period's low byte on phase zero.
    assign mixed = pos_cur ^ key_byte;
    assign delta = (phase_cur == 32'd0) ? 8'(mixed + cfg.period[7:0]) : mixed;

    // Counters advance once per byte; the phase wraps at the period.
    assign position_low_next = 8'(pos_cur + 8'd1);
    assign phase_inc         = {1'b0, phase_cur} + 33'd1;
    assign period_phase_next = (phase_inc >= {1'b0, cfg.period}) ? 32'd0 : phase_inc[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_low_reg <= 8'd0;
            period_phase_reg <= 32'd0;
            key_index_reg    <= '0;
        end
        else if (advance)
        begin
            position_low_reg <= position_low_next;
            period_phase_reg <= period_phase_next;
            key_index_reg    <= key_index_next;
        end
    end

    // A byte that opens a file leaves the position at one.
    `KBS_ASSERT_NEXT(a_sof_position, advance && start_of_file, position_low_reg == 8'd1,
                     "position not restarted by start of file")
    // Without a start of file the position counts up by one per byte.
    `KBS_ASSERT_NEXT(a_position_step, advance && !start_of_file,
                     position_low_reg == 8'($past(position_low_reg) + 8'd1),
                     "position did not step")

endmodule

`default_nettype wire

/* src/keyed_byte_scrambler.sv */
// Keyed byte scrambler: adds (encode) or subtracts (decode) a key stream
// offset to each byte of a file. An accepted request waits in the input
// register; its result enters the result register once that is empty or
// draining. One byte is accepted every cycle while the output side keeps up,
// and the key generator counters step once per byte. The output register
// lets a new request enter while a finished result still waits. Configuration
// needs no clearing pass; it should be written only while no byte is in flight.
// Depends on kbs_pkg, kbs_cfg_regs, kbs_key_gen and the macro header.
`default_nettype none
`include "keyed_byte_scrambler_macros.svh"

module keyed_byte_scrambler (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [7:0]                     data_byte,
    input  wire logic                           start_of_file,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [7:0]                          result_byte,
    input  wire logic                           cfg_write_en,
    input  wire logic [kbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kbs_pkg::CFG_DATA_W-1:0] cfg_data
);

    kbs_pkg::cfg_t cfg;

    logic       s1_valid_reg;
    logic [7:0] s1_data_reg;
    logic       s1_sof_reg;
    logic       out_valid_reg;
    logic [7:0] result_reg, result_next;
    logic       advance;
    logic [7:0] delta;

    kbs_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    kbs_key_gen u_key_gen (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .start_of_file (s1_sof_reg),
        .advance       (advance),
        .delta         (delta)
    );

    // The input stage moves on when the output register is free or drains.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || !out_valid_reg || out_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= data_byte;
            s1_sof_reg  <= start_of_file;
        end
    end

    // Apply the offset in the direction set by the mode.
    assign result_next = (cfg.mode == kbs_pkg::MODE_ENCODE) ? 8'(s1_data_reg + delta)
                                                            : 8'(s1_data_reg - delta);

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_byte = result_reg;

    // An empty output register never blocks a request.
    `KBS_ASSERT_SAME(a_ready_when_empty, !out_valid_reg, in_ready, "input stalled")
    // An accepted request is held in the input stage next cycle.
    `KBS_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, s1_valid_reg, "accepted request lost")
    // A byte leaving the input stage shows up as a result.
    `KBS_ASSERT_NEXT(a_advance_result, advance, out_valid_reg, "advanced byte has no result")

endmodule

`default_nettype wire

/* tb/sv/tb_keyed_byte_scrambler.sv */
// Self-checking testbench for keyed_byte_scrambler: directed and random byte files.
// It predicts every result byte from its own copy of the key, period and counters.
// Depends on kbs_pkg and the keyed_byte_scrambler RTL only.
`timescale 1ns / 100ps

module tb_keyed_byte_scrambler;

    localparam int OUT_LATENCY = 2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    typedef enum int {RX_STREAM, RX_RANDOM, RX_SPARSE, RX_BLOCKED} rx_style_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [7:0]                     data_byte = '0;
    logic                           start_of_file = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [7:0]                     result_byte;
    logic                           cfg_write_en = 1'b0;
    logic [kbs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [kbs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the configuration and of the key stream counters.
    kbs_pkg::cfg_t shadow_cfg;
    logic [7:0]    byte_pos;
    logic [31:0]   phase_count;
    logic [2:0]    key_sel;

    logic [7:0]  expected_bytes[$];
    int          bytes_sent = 0;
    int          bytes_checked = 0;
    int          files_started = 0;
    int          cfg_writes = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          rx_left = 0;
    rx_style_t   rx_style = RX_STREAM;

    keyed_byte_scrambler u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_byte   (result_byte),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Advances the shadow counters by one byte and returns the expected output.
    function automatic logic [7:0] scramble_step(input logic [7:0] din, input logic sof);
        logic [2:0] last_key;
        logic [7:0] offset;
        if (shadow_cfg.key_length == 4'd0)
            last_key = 3'd0;
        else if (shadow_cfg.key_length > kbs_pkg::KEY_DEPTH)
            last_key = 3'(kbs_pkg::KEY_DEPTH - 1);
        else
            last_key = 3'(shadow_cfg.key_length - 4'd1);
        if (sof)
        begin
            byte_pos = '0;
            phase_count = '0;
            key_sel = '0;
        end
        if (key_sel >= last_key)
            key_sel = '0;
        else
            key_sel = key_sel + 3'd1;
        offset = byte_pos ^ shadow_cfg.key_bytes[8 * key_sel +: 8];
        if (phase_count == 32'd0)
            offset = offset + shadow_cfg.period[7:0];
        byte_pos = byte_pos + 8'd1;
        // The phase wraps once it reaches the period; a zero period keeps it at zero.
        if ({1'b0, phase_count} + 33'd1 >= {1'b0, shadow_cfg.period})
            phase_count = '0;
        else
            phase_count = phase_count + 32'd1;
        return (shadow_cfg.mode == kbs_pkg::MODE_ENCODE) ? din + offset : din - offset;
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Sends one request; with gaps enabled the sender works in random bursts.
    task automatic send_byte(input logic [7:0] din, input logic sof, input bit use_gaps);
        if (use_gaps && burst_left == 0)
        begin
            if (in_valid)
                in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        in_valid <= 1'b1;
        data_byte <= din;
        start_of_file <= sof;
        do
            @(posedge clk);
        while (!in_ready);
        expected_bytes.push_back(scramble_step(din, sof));
        bytes_sent++;
        if (sof)
            files_started++;
        if (burst_left > 0)
            burst_left--;
    endtask

    // Holds off the sender until every expected byte has come back.
    task automatic wait_idle();
        if (in_valid)
            in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (OUT_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [kbs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [kbs_pkg::CFG_DATA_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        case (idx)
            kbs_pkg::REG_MODE:       shadow_cfg.mode = value[0];
            kbs_pkg::REG_PERIOD:     shadow_cfg.period = value[31:0];
            kbs_pkg::REG_KEY_LENGTH: shadow_cfg.key_length = value[3:0];
            kbs_pkg::REG_KEY_BYTES:  shadow_cfg.key_bytes = value;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic configure(input logic md, input logic [31:0] per,
                             input logic [3:0] klen, input logic [63:0] key);
        wait_idle();
        write_reg(kbs_pkg::REG_MODE, kbs_pkg::CFG_DATA_W'(md));
        write_reg(kbs_pkg::REG_PERIOD, kbs_pkg::CFG_DATA_W'(per));
        write_reg(kbs_pkg::REG_KEY_LENGTH, kbs_pkg::CFG_DATA_W'(klen));
        write_reg(kbs_pkg::REG_KEY_BYTES, key);
    endtask

    // Bytes before any start of file use the reset configuration and counters.
    task automatic test_reset_state();
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
    endtask

    // Data extremes in both directions with all eight key bytes in use.
    task automatic test_encode_extremes();
        configure(kbs_pkg::MODE_ENCODE, 32'd3, 4'd8, 64'h80A5_5A0F_F001_7FFE);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'hFE, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b1, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        wait_idle();
        write_reg(kbs_pkg::REG_MODE, kbs_pkg::CFG_DATA_W'(kbs_pkg::MODE_DECODE));
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
    endtask

    // A zero key length acts as one; lengths above the key depth saturate.
    task automatic test_key_length_limits();
        configure(kbs_pkg::MODE_ENCODE, 32'd7, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'h5A, 1'b1, 1'b0);
        send_byte(8'hA5, 1'b0, 1'b0);
        wait_idle();
        write_reg(kbs_pkg::REG_KEY_LENGTH, kbs_pkg::CFG_DATA_W'(4'd15));
        send_byte(8'h5A, 1'b1, 1'b0);
        send_byte(8'hA5, 1'b0, 1'b0);
    endtask

    // A zero period applies a zero addend on every byte; the largest never wraps early.
    task automatic test_period_limits();
        configure(kbs_pkg::MODE_DECODE, 32'd0, 4'd3, 64'h0011_2233_4455_6677);
        send_byte(8'h33, 1'b1, 1'b0);
        send_byte(8'hCC, 1'b0, 1'b0);
        wait_idle();
        write_reg(kbs_pkg::REG_PERIOD, kbs_pkg::CFG_DATA_W'(32'hFFFF_FFFF));
        send_byte(8'h33, 1'b1, 1'b0);
        send_byte(8'hCC, 1'b0, 1'b0);
    endtask

    // Lowering key length and period inside a file wraps the counters past them.
    task automatic test_reconfig_mid_file();
        configure(kbs_pkg::MODE_ENCODE, 32'd5, 4'd8, 64'h0102_0408_1020_4080);
        send_byte(8'h10, 1'b1, 1'b0);
        send_byte(8'h20, 1'b0, 1'b0);
        wait_idle();
        write_reg(kbs_pkg::REG_KEY_LENGTH, kbs_pkg::CFG_DATA_W'(4'd2));
        write_reg(kbs_pkg::REG_PERIOD, kbs_pkg::CFG_DATA_W'(32'd2));
        send_byte(8'h30, 1'b0, 1'b0);
        send_byte(8'h40, 1'b0, 1'b0);
    endtask

    task automatic random_config();
        logic [31:0] per;
        logic [3:0]  klen;
        case ($urandom_range(0, 7))
            0: per = 32'd1;
            1: per = $urandom_range(2, 8);
            2: per = $urandom_range(9, 40);
            3: per = $urandom_range(255, 257);
            4: per = $urandom;
            5: per = 32'd0;
            6: per = 32'hFFFF_FFFF;
            default: per = $urandom_range(1, 16);
        endcase
        if ($urandom_range(0, 4) == 0)
            klen = 4'($urandom_range(0, 15));
        else
            klen = 4'($urandom_range(1, 8));
        configure(logic'($urandom_range(0, 1)), per, klen, {$urandom, $urandom});
    endtask

    // Random files: mostly well-formed with random content, plus stray file starts.
    task automatic test_random_files();
        int  target;
        int  sent;
        int  file_left;
        int  drain_at;
        bit  gaps;
        logic sof;
        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase == 5)
            begin
                // One long file wraps the byte position past 256.
                configure(kbs_pkg::MODE_ENCODE, 32'd257, 4'd8, {$urandom, $urandom});
                target = 270;
            end
            else
            begin
                // Odd phases keep the current file running across the new setting.
                random_config();
                target = 16;
            end
            gaps = (phase % 4 != 3) && (phase != 5);
            file_left = (phase % 2 == 0) ? 0 : $urandom_range(1, 10);
            drain_at = $urandom_range(1, target - 1);
            sent = 0;
            while (sent < target)
            begin
                if (sent == drain_at)
                    wait_idle();
                if (file_left == 0)
                begin
                    sof = 1'b1;
                    file_left = (phase == 5) ? target : $urandom_range(1, 12);
                end
                else
                    sof = (phase != 5) && ($urandom_range(0, 19) == 0);
                send_byte(8'($urandom_range(0, 255)), sof, gaps);
                file_left--;
                sent++;
            end
        end
    endtask

    // Receiver: switches at random between stall patterns.
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_style = rx_style_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 80);
        end
        rx_left--;
        case (rx_style)
            RX_STREAM: out_ready <= 1'b1;
            RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= (rx_left % 4 == 0);
            default:   out_ready <= (rx_left % 16) < 4;
        endcase
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        logic [7:0] wanted;
        if (rst_n && out_valid && out_ready)
        begin
            bytes_checked++;
            if (expected_bytes.size() == 0)
                flag_error($sformatf("result 0x%02h with no request outstanding", result_byte));
            else
            begin
                wanted = expected_bytes.pop_front();
                if (result_byte !== wanted)
                    flag_error($sformatf("result %0d: expected 0x%02h, got 0x%02h",
                                         bytes_checked, wanted, result_byte));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_bytes.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        shadow_cfg = '{mode: kbs_pkg::MODE_DECODE, period: 32'd1, key_length: 4'd1,
                       key_bytes: 64'd0};
        byte_pos = '0;
        phase_count = '0;
        key_sel = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_encode_extremes();
        test_key_length_limits();
        test_period_limits();
        test_reconfig_mid_file();
        test_random_files();

        wait_idle();
        repeat (OUT_LATENCY + 4) @(posedge clk);

        $display("checked %0d result bytes from %0d requests in %0d files",
                 bytes_checked, bytes_sent, files_started);
        $display("%0d register writes, %0d mismatches", cfg_writes, mismatches);
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* keyed_byte_scrambler.f */
+incdir+src
src/kbs_pkg.sv
src/kbs_cfg_regs.sv
src/kbs_key_gen.sv
src/keyed_byte_scrambler.sv
tb/sv/tb_keyed_byte_scrambler.sv
